// File: hdl/pwfd_pkg.sv
// ----------------------------------------------------------------------------
// pwfd_pkg: shared types and constants for the pulse width frame decoder
// Command codes between front and back, register map, frame geometry.
// ----------------------------------------------------------------------------
package pwfd_pkg;

  localparam int unsigned FRAME_BITS  = 40;
  localparam int unsigned BIT_CNT_W   = 6;
  localparam int unsigned REJ_W       = 6;
  localparam int unsigned LEAD_W      = 4;
  localparam int unsigned APB_ADDR_W  = 5;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned CMD_Q_DEPTH = 4;
  localparam int unsigned CMD_Q_PTR_W = 2;
  localparam int unsigned CMD_Q_CNT_W = 3;

  localparam logic [REJ_W-1:0] REJ_MAX = '1;

  // Reset values of the timing windows, in ticks, and of the lead symbol count
  localparam int unsigned RST_SEP_MIN  = 44;
  localparam int unsigned RST_SEP_MAX  = 56;
  localparam int unsigned RST_ONE_MIN  = 66;
  localparam int unsigned RST_ONE_MAX  = 74;
  localparam int unsigned RST_ZERO_MIN = 20;
  localparam int unsigned RST_ZERO_MAX = 34;
  localparam int unsigned RST_LEAD     = 2;

  typedef enum logic [2:0] {
    REG_SEP_MIN  = 3'd0,
    REG_SEP_MAX  = 3'd1,
    REG_ONE_MIN  = 3'd2,
    REG_ONE_MAX  = 3'd3,
    REG_ZERO_MIN = 3'd4,
    REG_ZERO_MAX = 3'd5,
    REG_LEAD     = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_BAD   = 2'd1,
    OP_BIT   = 2'd2,
    OP_CLOSE = 2'd3
  } cmd_op_t;

  typedef struct packed {
    logic    start;
    cmd_op_t op;
    logic    bit_val;
  } cmd_t;

endpackage

// File: hdl/pwfd_sym_if.sv
// ----------------------------------------------------------------------------
// pwfd_sym_if: pulse symbol channel
// One captured symbol per request: two phases with level and duration, plus
// frame markers.
// ----------------------------------------------------------------------------
interface pwfd_sym_if #(
  parameter int unsigned DW = 15
);
  logic          valid;
  logic          ready;
  logic          first_level;
  logic [DW-1:0] first_time;
  logic          second_level;
  logic [DW-1:0] second_time;
  logic          frame_start;
  logic          frame_last;

  modport source (
    output valid, first_level, first_time, second_level, second_time,
           frame_start, frame_last,
    input  ready
  );

  modport sink (
    input  valid, first_level, first_time, second_level, second_time,
           frame_start, frame_last,
    output ready
  );
endinterface

// File: hdl/pwfd_res_if.sv
// ----------------------------------------------------------------------------
// pwfd_res_if: decoded frame channel
// One closed frame per request: humidity, temperature, checksum verdict and
// frame statistics.
// ----------------------------------------------------------------------------
interface pwfd_res_if;
  logic               valid;
  logic               ready;
  logic [15:0]        humidity_tenths;
  logic signed [15:0] temperature_tenths;
  logic               checksum_ok;
  logic [5:0]         bits_received;
  logic [5:0]         bad_symbols;

  modport source (
    output valid, humidity_tenths, temperature_tenths, checksum_ok,
           bits_received, bad_symbols,
    input  ready
  );

  modport sink (
    input  valid, humidity_tenths, temperature_tenths, checksum_ok,
           bits_received, bad_symbols,
    output ready
  );
endinterface

// File: hdl/pulse_width_frame_decoder.sv
// ----------------------------------------------------------------------------
// pulse_width_frame_decoder: single-wire sensor frame decoder
// Classifies pulse symbols into bits and closes frames into readings.
// ----------------------------------------------------------------------------
// Accepts one pulse symbol per clock while the queue has room. A classifier
// skips the lead symbols, checks the low separator window and sorts the high
// phase into a one or a zero by its window; its commands pass through a
// four-entry queue to a frame assembler that shifts up to 40 bits MSB first
// and counts bad symbols. A symbol marked frame_last closes the frame into a
// result register; that close waits only while the previous result is held,
// and the queue lets symbols keep coming meanwhile. Windows are inclusive and
// the one window wins on overlap. Results: humidity and signed temperature in
// tenths, checksum verdict, bit count and saturating bad-symbol count.
module pulse_width_frame_decoder #(
  parameter int unsigned DURATION_WIDTH = 15
) (
  input  logic                            clk,
  input  logic                            rst,
  pwfd_sym_if.sink                        symbol,
  pwfd_res_if.source                      result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pwfd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pwfd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pwfd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import pwfd_pkg::*;

  logic [DURATION_WIDTH-1:0] sep_min;
  logic [DURATION_WIDTH-1:0] sep_max;
  logic [DURATION_WIDTH-1:0] one_min;
  logic [DURATION_WIDTH-1:0] one_max;
  logic [DURATION_WIDTH-1:0] zero_min;
  logic [DURATION_WIDTH-1:0] zero_max;
  logic [LEAD_W-1:0]         lead_symbols;
  logic                      push;
  cmd_t                      push_cmd;
  logic                      push_ready;
  logic                      pop_valid;
  cmd_t                      pop_cmd;
  logic                      pop;

  pwfd_regs #(.DW(DURATION_WIDTH)) u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sep_min      (sep_min),
    .sep_max      (sep_max),
    .one_min      (one_min),
    .one_max      (one_max),
    .zero_min     (zero_min),
    .zero_max     (zero_max),
    .lead_symbols (lead_symbols)
  );

  pwfd_front #(.DW(DURATION_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .symbol       (symbol),
    .sep_min      (sep_min),
    .sep_max      (sep_max),
    .one_min      (one_min),
    .one_max      (one_max),
    .zero_min     (zero_min),
    .zero_max     (zero_max),
    .lead_symbols (lead_symbols),
    .push         (push),
    .push_cmd     (push_cmd),
    .push_ready   (push_ready)
  );

  pwfd_cmd_q u_cmd_q (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  pwfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .result    (result)
  );

endmodule

// File: hdl/pwfd_regs.sv
// ----------------------------------------------------------------------------
// pwfd_regs: configuration register bank
// APB-style write/read access to the timing windows and the lead count.
// ----------------------------------------------------------------------------
module pwfd_regs #(
  parameter int unsigned DW = 15
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pwfd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pwfd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pwfd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [DW-1:0]                    sep_min,
  output logic [DW-1:0]                    sep_max,
  output logic [DW-1:0]                    one_min,
  output logic [DW-1:0]                    one_max,
  output logic [DW-1:0]                    zero_min,
  output logic [DW-1:0]                    zero_max,
  output logic [pwfd_pkg::LEAD_W-1:0]      lead_symbols
);
  import pwfd_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_min      <= DW'(RST_SEP_MIN);
      sep_max      <= DW'(RST_SEP_MAX);
      one_min      <= DW'(RST_ONE_MIN);
      one_max      <= DW'(RST_ONE_MAX);
      zero_min     <= DW'(RST_ZERO_MIN);
      zero_max     <= DW'(RST_ZERO_MAX);
      lead_symbols <= LEAD_W'(RST_LEAD);
    end else if (wr_en) begin
      unique case (idx)
        REG_SEP_MIN:  sep_min      <= pwdata[DW-1:0];
        REG_SEP_MAX:  sep_max      <= pwdata[DW-1:0];
        REG_ONE_MIN:  one_min      <= pwdata[DW-1:0];
        REG_ONE_MAX:  one_max      <= pwdata[DW-1:0];
        REG_ZERO_MIN: zero_min     <= pwdata[DW-1:0];
        REG_ZERO_MAX: zero_max     <= pwdata[DW-1:0];
        REG_LEAD:     lead_symbols <= pwdata[LEAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SEP_MIN:  prdata = APB_DATA_W'(sep_min);
      REG_SEP_MAX:  prdata = APB_DATA_W'(sep_max);
      REG_ONE_MIN:  prdata = APB_DATA_W'(one_min);
      REG_ONE_MAX:  prdata = APB_DATA_W'(one_max);
      REG_ZERO_MIN: prdata = APB_DATA_W'(zero_min);
      REG_ZERO_MAX: prdata = APB_DATA_W'(zero_max);
      REG_LEAD:     prdata = APB_DATA_W'(lead_symbols);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: hdl/pwfd_front.sv
// ----------------------------------------------------------------------------
// pwfd_front: symbol classifier
// Accepts pulse symbols, skips lead symbols and turns each other symbol into a
// frame command for the back end.
// ----------------------------------------------------------------------------
module pwfd_front #(
  parameter int unsigned DW = 15
) (
  input  logic                        clk,
  input  logic                        rst,
  pwfd_sym_if.sink                    symbol,
  input  logic [DW-1:0]               sep_min,
  input  logic [DW-1:0]               sep_max,
  input  logic [DW-1:0]               one_min,
  input  logic [DW-1:0]               one_max,
  input  logic [DW-1:0]               zero_min,
  input  logic [DW-1:0]               zero_max,
  input  logic [pwfd_pkg::LEAD_W-1:0] lead_symbols,
  output logic                        push,
  output pwfd_pkg::cmd_t              push_cmd,
  input  logic                        push_ready
);
  import pwfd_pkg::*;

  logic [LEAD_W-1:0] pos;
  logic [LEAD_W-1:0] pos_eff;
  logic [LEAD_W-1:0] pos_next;
  logic              accept;
  logic              sep_ok;
  logic              is_one;
  logic              is_zero;

  assign symbol.ready = push_ready;
  assign accept       = symbol.valid && push_ready;

  assign sep_ok  = !symbol.second_level && (symbol.second_time >= sep_min)
                   && (symbol.second_time <= sep_max);
  assign is_one  = symbol.first_level && (symbol.first_time >= one_min)
                   && (symbol.first_time <= one_max);
  assign is_zero = symbol.first_level && (symbol.first_time >= zero_min)
                   && (symbol.first_time <= zero_max);

  always_comb begin
    pos_eff          = symbol.frame_start ? '0 : pos;
    pos_next         = pos_eff;
    push_cmd.start   = symbol.frame_start;
    push_cmd.op      = OP_NONE;
    push_cmd.bit_val = 1'b0;
    if (symbol.frame_last) begin
      push_cmd.op = OP_CLOSE;
      pos_next    = '0;
    end else if (pos_eff < lead_symbols) begin
      pos_next = pos_eff + LEAD_W'(1);
    end else if (sep_ok && (is_one || is_zero)) begin
      // one window wins where the windows overlap
      push_cmd.op      = OP_BIT;
      push_cmd.bit_val = is_one;
    end else begin
      push_cmd.op = OP_BAD;
    end
  end

  // drop lead symbols that carry no frame start
  assign push = accept && (symbol.frame_start || (push_cmd.op != OP_NONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

endmodule

// File: hdl/pwfd_cmd_q.sv
// ----------------------------------------------------------------------------
// pwfd_cmd_q: command queue
// Small FIFO between classifier and frame assembler.
// ----------------------------------------------------------------------------
module pwfd_cmd_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pwfd_pkg::cmd_t push_cmd,
  output logic           push_ready,
  output logic           pop_valid,
  output pwfd_pkg::cmd_t pop_cmd,
  input  logic           pop
);
  import pwfd_pkg::*;

  cmd_t                   entries [CMD_Q_DEPTH];
  logic [CMD_Q_PTR_W-1:0] wr_ptr;
  logic [CMD_Q_PTR_W-1:0] rd_ptr;
  logic [CMD_Q_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != CMD_Q_CNT_W'(CMD_Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + CMD_Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + CMD_Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CMD_Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CMD_Q_CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CMD_Q_CNT_W'(CMD_Q_DEPTH))
    else $error("command queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CMD_Q_CNT_W'(CMD_Q_DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("command queue pointers disagree with count");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + CMD_Q_CNT_W'(1)))
    else $error("command queue lost a push");
`endif

endmodule

// File: hdl/pwfd_back.sv
// ----------------------------------------------------------------------------
// pwfd_back: frame assembler
// Executes frame commands: shifts bits in, counts bad symbols, and closes
// frames into the result register.
// ----------------------------------------------------------------------------
module pwfd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  pwfd_pkg::cmd_t cmd,
  output logic           cmd_pop,
  pwfd_res_if.source     result
);
  import pwfd_pkg::*;

  logic [FRAME_BITS-1:0] frame_bits;
  logic [BIT_CNT_W-1:0]  bit_count;
  logic [REJ_W-1:0]      reject_count;
  logic [FRAME_BITS-1:0] bits_eff;
  logic [BIT_CNT_W-1:0]  cnt_eff;
  logic [REJ_W-1:0]      rej_eff;
  logic [FRAME_BITS-1:0] frame_bits_next;
  logic [BIT_CNT_W-1:0]  bit_count_next;
  logic [REJ_W-1:0]      reject_count_next;
  logic [BIT_CNT_W-1:0]  bit_idx;
  logic [7:0]            b0, b1, b2, b3, b4;
  logic [7:0]            sum8;
  logic [15:0]           mag;
  logic [15:0]           temp;
  logic                  res_load;

  assign cmd_pop  = cmd_valid && ((cmd.op != OP_CLOSE) || !result.valid || result.ready);
  assign res_load = cmd_pop && (cmd.op == OP_CLOSE);

  // apply frame start before the command itself
  assign bits_eff = cmd.start ? '0 : frame_bits;
  assign cnt_eff  = cmd.start ? '0 : bit_count;
  assign rej_eff  = cmd.start ? '0 : reject_count;
  assign bit_idx  = BIT_CNT_W'(FRAME_BITS - 1) - cnt_eff;

  assign b0   = bits_eff[39:32];
  assign b1   = bits_eff[31:24];
  assign b2   = bits_eff[23:16];
  assign b3   = bits_eff[15:8];
  assign b4   = bits_eff[7:0];
  assign sum8 = b0 + b1 + b2 + b3;
  assign mag  = {1'b0, b2[6:0], b3};
  assign temp = b2[7] ? (16'd0 - mag) : mag;

  always_comb begin
    frame_bits_next   = bits_eff;
    bit_count_next    = cnt_eff;
    reject_count_next = rej_eff;
    unique case (cmd.op)
      OP_NONE: ;
      OP_BAD: begin
        if (rej_eff != REJ_MAX) begin
          reject_count_next = rej_eff + REJ_W'(1);
        end
      end
      OP_BIT: begin
        // drop bits past the end of the frame
        if (cnt_eff < BIT_CNT_W'(FRAME_BITS)) begin
          frame_bits_next[bit_idx] = cmd.bit_val;
          bit_count_next           = cnt_eff + BIT_CNT_W'(1);
        end
      end
      OP_CLOSE: begin
        frame_bits_next   = '0;
        bit_count_next    = '0;
        reject_count_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits   <= '0;
      bit_count    <= '0;
      reject_count <= '0;
    end else if (cmd_pop) begin
      frame_bits   <= frame_bits_next;
      bit_count    <= bit_count_next;
      reject_count <= reject_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.humidity_tenths    <= {b0, b1};
      result.temperature_tenths <= temp;
      result.checksum_ok        <= (b4 == sum8);
      result.bits_received      <= cnt_eff;
      result.bad_symbols        <= rej_eff;
    end
  end

`ifndef SYNTH
  a_bit_count_bound: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BIT_CNT_W'(FRAME_BITS))
    else $error("bit count past frame length");

  a_empty_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (bit_count == '0) |-> (frame_bits == '0))
    else $error("frame bits set with no bit counted");

  a_close_loads: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (result.valid && (bit_count == '0) && (reject_count == '0)))
    else $error("frame close did not load result and clear state");
`endif

endmodule
